// ===== design/salb_pkg.sv =====
// Package for the suffix array and LCP builder.
// Holds request and status codes, payload structs and size defaults.
// Used by suffix_array_lcp_builder_unit in the design folder.
`timescale 1ns / 1ps
`default_nettype none

package salb_pkg;

    localparam int MAX_LEN_DEF   = 4096;
    localparam int FIRST_BUCKETS = 256;

    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_END    = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_ZERO = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;
    localparam logic [1:0] STAT_BAD  = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  data_byte;
        logic [11:0] entry_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] suffix_at_rank;
        logic [11:0] lcp_at_rank;
        logic [11:0] rank_of_position;
        logic [12:0] built_length;
    } t_out_item;

endpackage

`default_nettype wire

// ===== design/salb_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module salb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/suffix_array_lcp_builder_unit.sv =====
// Suffix array and LCP builder: loads bytes, sorts suffixes by prefix doubling
// with counting-sort passes, then builds the LCP array. Uses salb_pkg, salb_ram.
// Append and rejected requests are answered straight from IDLE; reads pass through READ.
// An end request loads the ranks, then runs counting-sort radix passes, a first ranking
// and doubling rounds, then the Kasai LCP pass; each memory has a single read port, and
// only one item is in flight at a time.
// Reset: synchronous, clears length, built flag, sequencer and output valid;
// the memories are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module suffix_array_lcp_builder_unit #(
    parameter int MAX_LEN = salb_pkg::MAX_LEN_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire salb_pkg::t_in_item   i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output salb_pkg::t_out_item       o_out_data
);

    localparam int AW      = $clog2(MAX_LEN);
    localparam int BUCKETS = (MAX_LEN > salb_pkg::FIRST_BUCKETS) ? MAX_LEN
                                                                 : salb_pkg::FIRST_BUCKETS;
    localparam int CAW     = $clog2(BUCKETS);
    localparam int IW      = $clog2(BUCKETS + 1);
    localparam int JW      = IW + 2;

    typedef enum logic [15:0] {
        ST_IDLE   = 16'b0000_0000_0000_0001,
        ST_READ   = 16'b0000_0000_0000_0010,
        ST_INIT   = 16'b0000_0000_0000_0100,
        ST_CLR    = 16'b0000_0000_0000_1000,
        ST_CNT    = 16'b0000_0000_0001_0000,
        ST_PFX    = 16'b0000_0000_0010_0000,
        ST_PLACE  = 16'b0000_0000_0100_0000,
        ST_CLS    = 16'b0000_0000_1000_0000,
        ST_T2R    = 16'b0000_0001_0000_0000,
        ST_SHIFT  = 16'b0000_0010_0000_0000,
        ST_SCAN   = 16'b0000_0100_0000_0000,
        ST_R2T    = 16'b0000_1000_0000_0000,
        ST_RERANK = 16'b0001_0000_0000_0000,
        ST_LCP0   = 16'b0010_0000_0000_0000,
        ST_LRANK  = 16'b0100_0000_0000_0000,
        ST_LCMP   = 16'b1000_0000_0000_0000
    } t_state;

    // memory ports
    logic           doc_we;  logic [AW-1:0]  doc_wa; logic [7:0]     doc_wd;
    logic [AW-1:0]  doc_ra;  logic [7:0]     doc_rd;
    logic           sa_we;   logic [AW-1:0]  sa_wa;  logic [AW-1:0]  sa_wd;
    logic [AW-1:0]  sa_ra;   logic [AW-1:0]  sa_rd;
    logic           rk_we;   logic [AW-1:0]  rk_wa;  logic [CAW-1:0] rk_wd;
    logic [AW-1:0]  rk_ra;   logic [CAW-1:0] rk_rd;
    logic           tm_we;   logic [AW-1:0]  tm_wa;  logic [AW-1:0]  tm_wd;
    logic [AW-1:0]  tm_ra;   logic [AW-1:0]  tm_rd;
    logic           lc_we;   logic [AW-1:0]  lc_wa;  logic [AW-1:0]  lc_wd;
    logic [AW-1:0]  lc_ra;   logic [AW-1:0]  lc_rd;
    logic           ct_we;   logic [CAW-1:0] ct_wa;  logic [IW-1:0]  ct_wd;
    logic [CAW-1:0] ct_ra;   logic [IW-1:0]  ct_rd;

    t_state           r_state, n_state;
    logic [1:0]       r_ph, n_ph;
    logic [IW-1:0]    r_i, n_i, r_wp, n_wp, r_n, n_n, r_len, n_len;
    logic [IW-1:0]    r_m, n_m, r_nb, n_nb, r_k, n_k, r_sum, n_sum, r_pk2, n_pk2;
    logic [JW-1:0]    r_j, n_j;
    logic [AW-1:0]    r_p, n_p, r_q, n_q, r_k1, n_k1, r_pk1, n_pk1;
    logic [CAW-1:0]   r_r, n_r;
    logic [7:0]       r_a8, n_a8, r_prev8, n_prev8;
    logic             r_built, n_built, r_first, n_first;
    logic             r_out_valid, n_out_valid;
    salb_pkg::t_out_item r_out, n_out;

    logic           in_xfer, last;
    logic [IW-1:0]  len_eff, m_new, k2, m_fin;
    logic [JW-1:0]  pj, j2;

    assign o_in_ready  = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign last        = (r_i == r_n - IW'(1));

    always_comb begin
        n_state = r_state;  n_ph = r_ph;    n_i = r_i;      n_wp = r_wp;
        n_n = r_n;          n_len = r_len;  n_m = r_m;      n_nb = r_nb;
        n_k = r_k;          n_sum = r_sum;  n_pk2 = r_pk2;  n_j = r_j;
        n_p = r_p;          n_q = r_q;      n_k1 = r_k1;    n_pk1 = r_pk1;
        n_r = r_r;          n_a8 = r_a8;    n_prev8 = r_prev8;
        n_built = r_built;  n_first = r_first;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out = r_out;
        doc_we = 1'b0; doc_wa = AW'(r_i); doc_wd = 8'd0; doc_ra = AW'(r_i);
        sa_we = 1'b0;  sa_wa = AW'(r_i);  sa_wd = '0;    sa_ra = AW'(r_i);
        rk_we = 1'b0;  rk_wa = AW'(r_i);  rk_wd = '0;    rk_ra = AW'(r_i);
        tm_we = 1'b0;  tm_wa = AW'(r_i);  tm_wd = '0;    tm_ra = AW'(r_i);
        lc_we = 1'b0;  lc_wa = AW'(r_i);  lc_wd = '0;    lc_ra = AW'(r_i);
        ct_we = 1'b0;  ct_wa = CAW'(r_i); ct_wd = '0;    ct_ra = CAW'(r_i);
        len_eff = r_len;
        m_new = r_m;
        k2 = '0;
        m_fin = r_m + IW'(1);
        pj = JW'(r_p) + r_j;
        j2 = r_j << 1;

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_out = '0;
                    n_out_valid = 1'b1;
                    case (i_in_data.req_type)
                        salb_pkg::REQ_APPEND: begin
                            if (i_in_data.data_byte == 8'd0) begin
                                n_out.status = salb_pkg::STAT_ZERO;
                            end else begin
                                len_eff = r_built ? '0 : r_len;
                                n_built = 1'b0;
                                n_len   = len_eff;
                                if (len_eff >= IW'(MAX_LEN - 1)) begin
                                    n_out.status = salb_pkg::STAT_FULL;
                                end else begin
                                    doc_we = 1'b1;
                                    doc_wa = AW'(len_eff);
                                    doc_wd = i_in_data.data_byte;
                                    n_len  = len_eff + IW'(1);
                                end
                            end
                        end
                        salb_pkg::REQ_END: begin
                            if (r_built) begin
                                n_out.built_length = 13'(r_len);
                            end else begin
                                // append the sentinel and start the build
                                doc_we = 1'b1;
                                doc_wa = AW'(r_len);
                                doc_wd = 8'd0;
                                n_len = r_len + IW'(1);
                                n_n   = r_len + IW'(1);
                                n_i   = '0;
                                n_ph  = 2'd0;
                                n_out_valid = 1'b0;
                                n_state = ST_INIT;
                            end
                        end
                        salb_pkg::REQ_READ: begin
                            if (!r_built) begin
                                n_out.status = salb_pkg::STAT_BAD;
                            end else if (JW'(i_in_data.entry_index) >= JW'(r_len)) begin
                                n_out.status = salb_pkg::STAT_BAD;
                                n_out.built_length = 13'(r_len);
                            end else begin
                                sa_ra = AW'(i_in_data.entry_index);
                                lc_ra = AW'(i_in_data.entry_index);
                                rk_ra = AW'(i_in_data.entry_index);
                                n_out_valid = 1'b0;
                                n_state = ST_READ;
                            end
                        end
                        default: begin
                            n_out.status = salb_pkg::STAT_BAD;
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_out.status           = salb_pkg::STAT_OK;
                n_out.suffix_at_rank   = 12'(sa_rd);
                n_out.lcp_at_rank      = 12'(lc_rd);
                n_out.rank_of_position = 12'(rk_rd);
                n_out.built_length     = 13'(r_len);
                n_out_valid = 1'b1;
                n_state = ST_IDLE;
            end
            ST_INIT: begin
                if (r_ph == 2'd0) begin
                    n_ph = 2'd1;
                end else begin
                    rk_we = 1'b1; rk_wd = CAW'(doc_rd);
                    tm_we = 1'b1; tm_wd = AW'(r_i);
                    n_ph = 2'd0;
                    n_i  = r_i + IW'(1);
                    if (last) begin
                        n_first = 1'b1;
                        n_nb    = IW'(salb_pkg::FIRST_BUCKETS);
                        n_i     = '0;
                        n_state = ST_CLR;
                    end
                end
            end
            ST_CLR: begin
                ct_we = 1'b1;
                n_i = r_i + IW'(1);
                if (r_i == r_nb - IW'(1)) begin
                    n_i = '0;
                    n_ph = 2'd0;
                    n_state = ST_CNT;
                end
            end
            ST_CNT: begin
                // tmp -> rank -> bucket count, then write back the increment
                n_ph = r_ph + 2'd1;
                case (r_ph)
                    2'd0: ;
                    2'd1: rk_ra = tm_rd;
                    2'd2: begin
                        ct_ra = rk_rd;
                        n_r = rk_rd;
                    end
                    default: begin
                        ct_we = 1'b1; ct_wa = r_r; ct_wd = ct_rd + IW'(1);
                        n_i = r_i + IW'(1);
                        if (last) begin
                            n_i = '0;
                            n_sum = '0;
                            n_state = ST_PFX;
                        end
                    end
                endcase
            end
            ST_PFX: begin
                if (r_ph == 2'd0) begin
                    n_ph = 2'd1;
                end else begin
                    n_sum = r_sum + ct_rd;
                    ct_we = 1'b1; ct_wd = r_sum + ct_rd;
                    n_ph = 2'd0;
                    n_i = r_i + IW'(1);
                    if (r_i == r_nb - IW'(1)) begin
                        n_i = r_n;
                        n_state = ST_PLACE;
                    end
                end
            end
            ST_PLACE: begin
                n_ph = r_ph + 2'd1;
                case (r_ph)
                    2'd0: tm_ra = AW'(r_i - IW'(1));
                    2'd1: begin
                        n_p = tm_rd;
                        rk_ra = tm_rd;
                    end
                    2'd2: begin
                        n_r = rk_rd;
                        ct_ra = rk_rd;
                    end
                    default: begin
                        ct_we = 1'b1; ct_wa = r_r; ct_wd = ct_rd - IW'(1);
                        sa_we = 1'b1; sa_wa = AW'(ct_rd - IW'(1)); sa_wd = r_p;
                        n_i = r_i - IW'(1);
                        if (r_i == IW'(1)) begin
                            n_i = '0;
                            n_m = '0;
                            n_state = r_first ? ST_CLS : ST_R2T;
                        end
                    end
                endcase
            end
            ST_CLS: begin
                // first ranks: count byte changes along the sorted order
                case (r_ph)
                    2'd0: n_ph = 2'd1;
                    2'd1: begin
                        n_p = sa_rd;
                        doc_ra = sa_rd;
                        n_ph = 2'd2;
                    end
                    default: begin
                        m_new = ((r_i != '0) && (doc_rd != r_prev8)) ? r_m + IW'(1) : r_m;
                        tm_we = 1'b1; tm_wa = r_p; tm_wd = AW'(m_new);
                        n_m = m_new;
                        n_prev8 = doc_rd;
                        n_ph = 2'd0;
                        n_i = r_i + IW'(1);
                        if (last) begin
                            n_i = '0;
                            n_state = ST_T2R;
                        end
                    end
                endcase
            end
            ST_T2R: begin
                if (r_ph == 2'd0) begin
                    n_ph = 2'd1;
                end else begin
                    rk_we = 1'b1; rk_wd = CAW'(tm_rd);
                    n_ph = 2'd0;
                    n_i = r_i + IW'(1);
                    if (last) begin
                        n_m = m_fin;
                        n_j = JW'(1);
                        n_wp = '0;
                        n_i = r_n - IW'(1);
                        n_state = (m_fin < r_n) ? ST_SHIFT : ST_LCP0;
                    end
                end
            end
            ST_SHIFT: begin
                // positions whose second half runs past the end sort first
                tm_we = 1'b1; tm_wa = AW'(r_wp); tm_wd = AW'(r_i);
                n_wp = r_wp + IW'(1);
                n_i = r_i + IW'(1);
                if (last) begin
                    n_i = '0;
                    n_ph = 2'd0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_ph == 2'd0) begin
                    n_ph = 2'd1;
                end else begin
                    if (JW'(sa_rd) >= r_j) begin
                        tm_we = 1'b1; tm_wa = AW'(r_wp); tm_wd = AW'(JW'(sa_rd) - r_j);
                        n_wp = r_wp + IW'(1);
                    end
                    n_ph = 2'd0;
                    n_i = r_i + IW'(1);
                    if (last) begin
                        n_first = 1'b0;
                        n_nb = r_m;
                        n_i = '0;
                        n_state = ST_CLR;
                    end
                end
            end
            ST_R2T: begin
                if (r_ph == 2'd0) begin
                    n_ph = 2'd1;
                end else begin
                    tm_we = 1'b1; tm_wd = AW'(rk_rd);
                    n_ph = 2'd0;
                    n_i = r_i + IW'(1);
                    if (last) begin
                        n_i = '0;
                        n_m = '0;
                        n_state = ST_RERANK;
                    end
                end
            end
            ST_RERANK: begin
                n_ph = r_ph + 2'd1;
                case (r_ph)
                    2'd0: ;
                    2'd1: begin
                        n_p = sa_rd;
                        tm_ra = sa_rd;
                    end
                    2'd2: begin
                        n_k1 = tm_rd;
                        tm_ra = AW'(pj);
                    end
                    default: begin
                        k2 = (pj < JW'(r_n)) ? IW'(tm_rd) + IW'(1) : '0;
                        m_new = ((r_i != '0) && ((r_k1 != r_pk1) || (k2 != r_pk2)))
                                ? r_m + IW'(1) : r_m;
                        m_fin = m_new + IW'(1);
                        rk_we = 1'b1; rk_wa = r_p; rk_wd = CAW'(m_new);
                        n_m = m_new;
                        n_pk1 = r_k1;
                        n_pk2 = k2;
                        n_i = r_i + IW'(1);
                        if (last) begin
                            n_m = m_fin;
                            n_j = j2;
                            n_wp = '0;
                            n_i = (JW'(r_n) > j2) ? IW'(JW'(r_n) - j2) : '0;
                            if ((r_j >= JW'(r_n)) || (m_fin >= r_n)) begin
                                n_state = ST_LCP0;
                            end else begin
                                n_state = ST_SHIFT;
                            end
                        end
                    end
                endcase
            end
            ST_LCP0: begin
                lc_we = 1'b1; lc_wa = '0; lc_wd = '0;
                n_k = '0;
                n_i = '0;
                n_ph = 2'd0;
                n_state = ST_LRANK;
            end
            ST_LRANK: begin
                case (r_ph)
                    2'd0: n_ph = 2'd1;
                    2'd1: begin
                        n_r = rk_rd;
                        if (rk_rd == '0) begin
                            n_k = '0;
                            n_ph = 2'd0;
                            n_i = r_i + IW'(1);
                            if (last) begin
                                n_built = 1'b1;
                                n_out = '0;
                                n_out.built_length = 13'(r_n);
                                n_out_valid = 1'b1;
                                n_state = ST_IDLE;
                            end
                        end else begin
                            if (r_k != '0) begin
                                n_k = r_k - IW'(1);
                            end
                            sa_ra = AW'(rk_rd - CAW'(1));
                            n_ph = 2'd2;
                        end
                    end
                    default: begin
                        n_q = sa_rd;
                        n_ph = 2'd0;
                        n_state = ST_LCMP;
                    end
                endcase
            end
            ST_LCMP: begin
                // extend the match one byte pair at a time
                case (r_ph)
                    2'd0: begin
                        if (((r_i + r_k) < r_n) && ((IW'(r_q) + r_k) < r_n)) begin
                            doc_ra = AW'(r_i + r_k);
                            n_ph = 2'd1;
                        end else begin
                            lc_we = 1'b1; lc_wa = AW'(r_r); lc_wd = AW'(r_k);
                            n_i = r_i + IW'(1);
                            n_state = ST_LRANK;
                            if (last) begin
                                n_built = 1'b1;
                                n_out = '0;
                                n_out.built_length = 13'(r_n);
                                n_out_valid = 1'b1;
                                n_state = ST_IDLE;
                            end
                        end
                    end
                    2'd1: begin
                        n_a8 = doc_rd;
                        doc_ra = AW'(IW'(r_q) + r_k);
                        n_ph = 2'd2;
                    end
                    default: begin
                        n_ph = 2'd0;
                        if (doc_rd == r_a8) begin
                            n_k = r_k + IW'(1);
                        end else begin
                            lc_we = 1'b1; lc_wa = AW'(r_r); lc_wd = AW'(r_k);
                            n_i = r_i + IW'(1);
                            n_state = ST_LRANK;
                            if (last) begin
                                n_built = 1'b1;
                                n_out = '0;
                                n_out.built_length = 13'(r_n);
                                n_out_valid = 1'b1;
                                n_state = ST_IDLE;
                            end
                        end
                    end
                endcase
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ph        <= 2'd0;
            r_len       <= '0;
            r_built     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ph        <= n_ph;
            r_len       <= n_len;
            r_built     <= n_built;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i;      r_wp <= n_wp;    r_n <= n_n;      r_m <= n_m;
        r_nb <= n_nb;    r_k <= n_k;      r_sum <= n_sum;  r_pk2 <= n_pk2;
        r_j <= n_j;      r_p <= n_p;      r_q <= n_q;      r_k1 <= n_k1;
        r_pk1 <= n_pk1;  r_r <= n_r;      r_a8 <= n_a8;    r_prev8 <= n_prev8;
        r_first <= n_first;
        r_out <= n_out;
    end

    salb_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_doc (
        .i_clk(i_clk), .i_we(doc_we), .i_waddr(doc_wa), .i_wdata(doc_wd),
        .i_raddr(doc_ra), .o_rdata(doc_rd)
    );
    salb_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_sa (
        .i_clk(i_clk), .i_we(sa_we), .i_waddr(sa_wa), .i_wdata(sa_wd),
        .i_raddr(sa_ra), .o_rdata(sa_rd)
    );
    salb_ram #(.WIDTH(CAW), .DEPTH(MAX_LEN)) u_rank (
        .i_clk(i_clk), .i_we(rk_we), .i_waddr(rk_wa), .i_wdata(rk_wd),
        .i_raddr(rk_ra), .o_rdata(rk_rd)
    );
    salb_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_tmp (
        .i_clk(i_clk), .i_we(tm_we), .i_waddr(tm_wa), .i_wdata(tm_wd),
        .i_raddr(tm_ra), .o_rdata(tm_rd)
    );
    salb_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_lcp (
        .i_clk(i_clk), .i_we(lc_we), .i_waddr(lc_wa), .i_wdata(lc_wd),
        .i_raddr(lc_ra), .o_rdata(lc_rd)
    );
    salb_ram #(.WIDTH(IW), .DEPTH(BUCKETS)) u_cnt (
        .i_clk(i_clk), .i_we(ct_we), .i_waddr(ct_wa), .i_wdata(ct_wd),
        .i_raddr(ct_ra), .o_rdata(ct_rd)
    );

`ifndef SYNTHESIS
    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == ST_IDLE))
        else $error("input ready outside idle");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |-> (!r_out_valid || i_out_ready))
        else $error("transfer accepted over a pending result");
    a_built_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_built |-> ((r_len != '0) && (r_len <= IW'(MAX_LEN))))
        else $error("built document with bad length");
    a_build_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (i_in_data.req_type == salb_pkg::REQ_END) && !r_built)
        |=> (!o_out_valid && (r_state == ST_INIT)))
        else $error("build did not start");
`endif

endmodule

`default_nettype wire
